FILE: src/ud64_pkg.sv
// Shared types and constants for the 64-bit unsigned divider.
// Holds the request and result structs and the pipeline control struct.
// No dependencies.
package ud64_pkg;

	// Width of the request and result fields on the ports.
	localparam int FIELD_WIDTH = 64;

	// Number of bits actually divided; inputs are masked to this width.
	localparam int DATA_WIDTH = 64;

	// Cycles from an accepted request to its result strobe.
	localparam int LATENCY = DATA_WIDTH + 1;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] dividend;
		logic [FIELD_WIDTH-1:0] divisor;
	} req_t;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] quotient;
		logic                   divide_by_zero;
	} rsp_t;

	// Control that travels alongside the data through every stage.
	typedef struct packed {
		logic valid;
		logic dbz;
	} ctl_t;

endpackage

FILE: src/ud64_pipe.sv
// Restoring division pipeline: one quotient bit per register stage.
// Depends on ud64_pkg for the data width and the control struct.
module ud64_pipe (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ud64_pkg::ctl_t                   in_ctl,
	input  logic [ud64_pkg::DATA_WIDTH-1:0]  in_rem,
	input  logic [ud64_pkg::DATA_WIDTH-1:0]  in_dsr,
	output ud64_pkg::ctl_t                   out_ctl,
	output logic [ud64_pkg::DATA_WIDTH-1:0]  out_quo
);
	import ud64_pkg::*;

	ctl_t                  ctl_s [DATA_WIDTH];
	logic [DATA_WIDTH-1:0] quo_s [DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem_s [DATA_WIDTH-1];
	logic [DATA_WIDTH-1:0] dsr_s [DATA_WIDTH-1];

	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
		localparam int POS = DATA_WIDTH - 1 - k;

		ctl_t                  c_in;
		logic [DATA_WIDTH-1:0] rem_in;
		logic [DATA_WIDTH-1:0] dsr_in;
		logic [DATA_WIDTH-1:0] quo_in;
		logic [DATA_WIDTH-1:0] quo_nxt;
		logic                  take;

		if (k == 0) begin : g_first
			assign c_in   = in_ctl;
			assign rem_in = in_rem;
			assign dsr_in = in_dsr;
			assign quo_in = '0;
		end else begin : g_next
			assign c_in   = ctl_s[k-1];
			assign rem_in = rem_s[k-1];
			assign dsr_in = dsr_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// The remainder shifted down is compared, so the divisor is never
		// shifted past the top of the word when the bit is taken.
		always_comb begin
			take          = (rem_in >> POS) >= dsr_in;
			quo_nxt       = quo_in;
			quo_nxt[POS]  = take;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= c_in;
			end
		end

		always_ff @(posedge clk) begin
			quo_s[k] <= quo_nxt;
		end

		// The last stage needs no remainder or divisor after it.
		if (k < DATA_WIDTH - 1) begin : g_carry
			logic [DATA_WIDTH-1:0] rem_nxt;

			assign rem_nxt = take ? rem_in - (dsr_in << POS) : rem_in;

			always_ff @(posedge clk) begin
				rem_s[k] <= rem_nxt;
				dsr_s[k] <= dsr_in;
			end
		end
	end

	assign out_ctl = ctl_s[DATA_WIDTH-1];
	assign out_quo = quo_s[DATA_WIDTH-1];

endmodule

FILE: src/unsigned_divider_64_unit.sv
// Top level of the 64-bit unsigned restoring divider.
// Depends on ud64_pkg and instantiates ud64_pipe.
//
// Usage: a request (dividend, divisor) is taken at a rising clock edge at
// which start is high and busy is low. The divider is fully pipelined, so
// busy stays low and a new request may be given in every cycle.
// The result (quotient, divide_by_zero) shows on the result port for exactly
// one cycle, marked by done, once the request has passed through the
// pipeline: one input register stage followed by 64 stages, each of which
// settles one quotient bit with a single 64-bit compare and subtract.
// Results leave in the order their requests came in, one per request.
// A zero divisor gives an all-ones quotient with divide_by_zero set.
// The receiver cannot stall the block; it must take each result in the
// cycle in which done is high.
// Reset (arst_n low) clears every valid bit at once, so requests in flight
// are dropped and no result comes out until a new request is taken. The
// data registers are not reset.
module unsigned_divider_64_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ud64_pkg::req_t request,
	output logic           done,
	output ud64_pkg::rsp_t result
);
	import ud64_pkg::*;

	localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

	ctl_t                  ctl_s1;
	logic [DATA_WIDTH-1:0] rem_s1;
	logic [DATA_WIDTH-1:0] dsr_s1;
	ctl_t                  pipe_ctl;
	logic [DATA_WIDTH-1:0] pipe_quo;

	// The pipeline never holds anything back.
	assign busy = 1'b0;

	// Input stage: register the request, masked to the divided width, and
	// note a zero divisor. A zero divisor needs no special path below: every
	// compare against zero succeeds, so the quotient comes out all ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start && !busy;
			ctl_s1.dbz   <= request.divisor[DATA_WIDTH-1:0] == '0;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1 <= request.dividend[DATA_WIDTH-1:0];
		dsr_s1 <= request.divisor[DATA_WIDTH-1:0];
	end

	ud64_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_s1),
		.in_rem  (rem_s1),
		.in_dsr  (dsr_s1),
		.out_ctl (pipe_ctl),
		.out_quo (pipe_quo)
	);

	assign done                  = pipe_ctl.valid;
	assign result.quotient       = FIELD_WIDTH'(pipe_quo);
	assign result.divide_by_zero = pipe_ctl.dbz;

	// Every request taken gives a result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("request taken but no result after the pipeline latency");

	// No result appears without a request taken the fixed latency before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching request");

	// A zero divisor must have driven every quotient bit to one.
	a_dbz_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_by_zero |-> result.quotient == FIELD_WIDTH'(ALL_ONES))
		else $error("divide by zero flagged without an all-ones quotient");

endmodule

FILE: test/tb_unsigned_divider_64_unit.sv
// Self-checking testbench for the 64-bit unsigned divider unit.
// Depends on ud64_pkg and unsigned_divider_64_unit; a scoreboard class predicts each quotient.
`timescale 1ns / 100ps

module tb_unsigned_divider_64_unit;
	import ud64_pkg::*;

	// The run is cut off here.
	localparam int CYCLE_LIMIT = 200000;

	// Number of random requests in each idling phase.
	localparam int PHASE_REQUESTS = 350;

	// The scoreboard works out the quotient of every accepted request with its own
	// restoring division. It then holds the quotients in arrival order until the
	// block hands them back.
	class quotient_scoreboard;
		rsp_t pending_quotients[$];
		int   mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Restoring division over DATA_WIDTH bits. The partial remainder is shifted
		// down rather than the divisor up, so no intermediate value can overflow.
		function rsp_t divide(req_t req);
			logic [FIELD_WIDTH-1:0] mask;
			logic [FIELD_WIDTH-1:0] rem;
			logic [FIELD_WIDTH-1:0] dsr;
			rsp_t                   rsp;
			mask = (DATA_WIDTH >= FIELD_WIDTH) ? '1 :
				(({{(FIELD_WIDTH-1){1'b0}}, 1'b1} << DATA_WIDTH) - 1'b1);
			rem = req.dividend & mask;
			dsr = req.divisor & mask;
			rsp = '0;
			if (dsr == '0) begin
				rsp.quotient       = mask;
				rsp.divide_by_zero = 1'b1;
				return rsp;
			end
			for (int pos = DATA_WIDTH - 1; pos >= 0; pos--) begin
				if ((rem >> pos) >= dsr) begin
					rem                = rem - (dsr << pos);
					rsp.quotient[pos]  = 1'b1;
				end
			end
			return rsp;
		endfunction

		function void note_request(req_t req);
			pending_quotients.push_back(divide(req));
		endfunction

		function int pending();
			return pending_quotients.size();
		endfunction

		task report_mismatch(string what, logic [FIELD_WIDTH-1:0] got,
				logic [FIELD_WIDTH-1:0] want);
			mismatches++;
			$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		endtask

		task check_result(rsp_t rsp);
			rsp_t want;
			if (pending_quotients.size() == 0) begin
				report_mismatch("unexpected result", rsp.quotient, '0);
				return;
			end
			want = pending_quotients.pop_front();
			if (rsp.quotient !== want.quotient)
				report_mismatch("quotient", rsp.quotient, want.quotient);
			if (rsp.divide_by_zero !== want.divide_by_zero)
				report_mismatch("divide_by_zero", FIELD_WIDTH'(rsp.divide_by_zero),
					FIELD_WIDTH'(want.divide_by_zero));
		endtask
	endclass

	logic clk     = 1'b0;
	logic arst_n  = 1'b0;
	logic start   = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;
	int   cycle_count = 0;

	quotient_scoreboard sb = new();

	unsigned_divider_64_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	always #6 clk = ~clk;

	// The receiver cannot stall the block, so every strobed result is checked at
	// the edge that ends its cycle. Outputs are sampled before the block's own
	// updates at that edge take effect.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Watchdog. It also catches results that never arrive.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[%0t] timeout with %0d quotients outstanding", $realtime, sb.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offers one request. Before it, the sender goes quiet for each cycle with
	// the given chance in percent. The request is held until an edge at which
	// busy is low takes it. Start stays high from one request into the next, so
	// back-to-back requests see no gap.
	task automatic send_request(input logic [FIELD_WIDTH-1:0] dividend,
			input logic [FIELD_WIDTH-1:0] divisor, input int idle_pct);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= '{dividend: dividend, divisor: divisor};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(request);
	endtask

	// Stops sending and waits for every outstanding quotient. This lets the
	// pipeline drain completely between phases.
	task automatic drain_requests();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// A random operand with a random magnitude. Shifting down a full-width
	// random value gives quotients of every length, not only tiny ones.
	function automatic logic [FIELD_WIDTH-1:0] random_operand();
		logic [FIELD_WIDTH-1:0] full;
		full = {$urandom, $urandom};
		if ($urandom_range(3, 0) == 0)
			return full;
		return full >> $urandom_range(FIELD_WIDTH - 1, 0);
	endfunction

	// One phase of random requests. Divisors are drawn from classes that steer
	// the division toward its interesting corners: zero, tiny, equal to the
	// dividend, just above it, powers of two, and general values.
	task automatic random_phase(input int count, input int idle_pct);
		logic [FIELD_WIDTH-1:0] dividend;
		logic [FIELD_WIDTH-1:0] divisor;
		for (int i = 0; i < count; i++) begin
			dividend = ($urandom_range(15, 0) == 0) ? '1 : random_operand();
			case ($urandom_range(11, 0))
				0: begin
					divisor = '0;
				end
				1: begin
					divisor = FIELD_WIDTH'($urandom_range(15, 1));
				end
				2: begin
					divisor = dividend;
				end
				3: begin
					divisor = dividend + $urandom_range(1000, 1);
				end
				4: begin
					divisor = {{(FIELD_WIDTH-1){1'b0}}, 1'b1} << $urandom_range(FIELD_WIDTH - 1, 0);
				end
				default: begin
					divisor = random_operand();
				end
			endcase
			send_request(dividend, divisor, idle_pct);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: zero divisors, the field extremes, a dividend below
		// its divisor, exact divisions, and alternating bit patterns.
		send_request(64'h0, 64'h0, 8);
		send_request('1, 64'h0, 8);
		send_request(64'h1234_5678_9abc_def0, 64'h0, 8);
		send_request(64'h0, 64'h1, 8);
		send_request('1, 64'h1, 8);
		send_request('1, '1, 8);
		send_request(64'hffff_ffff_ffff_fffe, '1, 8);
		send_request(64'h0, '1, 8);
		send_request(64'h1, 64'h2, 8);
		send_request('1, 64'h2, 8);
		send_request(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 8);
		send_request(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 8);
		send_request('1, 64'h8000_0000_0000_0000, 8);
		send_request(64'h8000_0000_0000_0000, 64'h3, 8);
		send_request(64'h8000_0000_0000_0000, 64'h1, 8);
		send_request(64'd12345, 64'd7, 8);
		send_request(64'd7, 64'd12345, 8);
		send_request(64'd1000000, 64'd1000, 8);
		send_request('1, 64'h0000_0000_ffff_ffff, 8);
		send_request(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 8);
		send_request(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 8);
		send_request(64'haaaa_aaaa_aaaa_aaaa, 64'h3, 8);
		send_request(64'hffff_ffff_0000_0000, 64'h0000_0001_0000_0000, 8);

		// Before each phase the sender holds off until the pipeline is empty, then
		// carries on with sparse idling, heavy idling, and none at all.
		drain_requests();
		random_phase(PHASE_REQUESTS, 8);
		drain_requests();
		random_phase(PHASE_REQUESTS, 53);
		drain_requests();
		random_phase(PHASE_REQUESTS, 0);
		start <= 1'b0;

		// Wait for the outstanding quotients, with a bound. Then watch one more
		// pipeline length so that a stray late result would be caught.
		for (int i = 0; i < 4 * LATENCY && sb.pending() != 0; i++)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch("missing results", FIELD_WIDTH'(sb.pending()), '0);

		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
